>>> sv/bagm_pkg.sv
// Shared constants, types and the glyph table of the block average glyph mapper.
package bagm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_BLOCK   = 64;
    localparam int GLYPH_COUNT = 48;

    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 16;
    localparam int BLOCK_W  = 7;
    localparam int CFG_W    = 16;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int TILE_W   = $clog2(MAX_BLOCK);
    localparam int SUM_W    = 22;
    localparam int COUNT_W  = 2 * TILE_W + 1;
    localparam int IDX_W    = $clog2(GLYPH_COUNT);

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_BLOCK_SIZE   = 2'd2,
        REG_INVERT_MAP   = 2'd3
    } cfg_index_t;

    function automatic logic [7:0] glyph_lookup(input logic [IDX_W-1:0] idx);
        logic [7:0] code;
        unique case (idx)
            6'd0:    code = "N";
            6'd1:    code = "@";
            6'd2:    code = "#";
            6'd3:    code = "W";
            6'd4:    code = "$";
            6'd5:    code = "9";
            6'd6:    code = "8";
            6'd7:    code = "7";
            6'd8:    code = "6";
            6'd9:    code = "5";
            6'd10:   code = "4";
            6'd11:   code = "3";
            6'd12:   code = "2";
            6'd13:   code = "1";
            6'd14:   code = "0";
            6'd15:   code = "?";
            6'd16:   code = "!";
            6'd17:   code = "a";
            6'd18:   code = "b";
            6'd19:   code = "c";
            6'd20:   code = ";";
            6'd21:   code = ":";
            6'd22:   code = "+";
            6'd23:   code = "=";
            6'd24:   code = "-";
            6'd25:   code = ",";
            6'd26:   code = ".";
            6'd27:   code = "_";
            default: code = " ";
        endcase
        return code;
    endfunction

endpackage

>>> sv/bagm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bagm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/bagm_div.sv
// Restoring divider that produces one quotient bit per cycle.
module bagm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bagm_pkg::SUM_W-1:0]    dividend,
    input  logic [bagm_pkg::COUNT_W-1:0]  divisor,
    output logic                          busy,
    output logic [bagm_pkg::SUM_W-1:0]    quotient
);
    import bagm_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0]   dvs_reg, dvs_next;
    logic [COUNT_W:0]     shifted;
    logic                 fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? COUNT_W'(shifted - {1'b0, dvs_reg}) : shifted[COUNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/block_average_glyph_mapper_top.sv
// Top level of the block average glyph mapper.
//
// Pixels arrive on the input channel (in_valid, in_stall, chan_a/b/c) in raster
// order, one word per pixel. The block sums all three channels over square tiles
// and emits one glyph word per tile on the output channel (out_valid, out_stall,
// glyph, row_end), with row_end set on the last tile of a tile row.
// A pixel that closes a tile row segment also passes through a write-back state,
// since the partial sum of its tile column is read from and written back to a
// line store RAM of one entry per tile column.
// A pixel that completes a tile also waits for the bit-serial divider that forms
// sum over pixel count and for the load of the output register; the next pixel
// is taken only after its glyph has been loaded.
// The output register holds a finished glyph while the receiver stalls; pixels
// keep being accepted until the next completed tile needs that register.
// Configuration writes on cfg_we, cfg_index and cfg_data restart the image.
// Reset restores width, height and block size of one, clears the inversion and
// restarts the image; the line store needs no clearing.
module block_average_glyph_mapper_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   chan_a,
    input  logic [7:0]                   chan_b,
    input  logic [7:0]                   chan_c,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   glyph,
    output logic                         row_end,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [bagm_pkg::CFG_W-1:0]   cfg_data
);
    import bagm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WB,
        ST_DIV
    } state_t;

    state_t               state_reg, state_next;
    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic [HEIGHT_W-1:0]  height_reg, height_next;
    logic [BLOCK_W-1:0]   block_reg, block_next;
    logic                 invert_reg, invert_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [HEIGHT_W-1:0]  row_reg, row_next;
    logic [TILE_W-1:0]    rit_reg, rit_next;
    logic [TILE_W-1:0]    cit_reg, cit_next;
    logic [COL_W-1:0]     tile_reg, tile_next;
    logic [SUM_W-1:0]     run_reg, run_next;
    logic [SUM_W-1:0]     pend_sum_reg, pend_sum_next;
    logic [COL_W-1:0]     pend_tile_reg, pend_tile_next;
    logic                 pend_acc_reg, pend_acc_next;
    logic                 pend_out_reg, pend_out_next;
    logic                 pend_last_reg, pend_last_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           glyph_reg, glyph_next;
    logic                 row_end_reg, row_end_next;

    logic [WIDTH_W-1:0]   w_eff;
    logic [BLOCK_W-1:0]   b_eff;
    logic [HEIGHT_W-1:0]  h_eff;
    logic [9:0]           px;
    logic                 accept;
    logic                 last_col, last_row, seg_end, tile_last_row;
    logic [SUM_W-1:0]     run_sum;
    logic [2*BLOCK_W-1:0] count_full;
    logic                 mem_we;
    logic [SUM_W-1:0]     mem_wdata, mem_rdata;
    logic                 div_start, div_busy;
    logic [SUM_W-1:0]     div_quo;
    logic [19:0]          third_prod;
    logic [7:0]           avg;
    logic [IDX_W+7:0]     scaled;
    logic [IDX_W-1:0]     idx;

    bagm_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (pend_tile_reg),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (tile_reg),
        .rdata (mem_rdata)
    );

    bagm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mem_wdata),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_comb
    begin
        w_eff = (width_reg == '0) ? WIDTH_W'(1) :
                (width_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_reg;
        b_eff = (block_reg == '0) ? BLOCK_W'(1) :
                (block_reg > BLOCK_W'(MAX_BLOCK)) ? BLOCK_W'(MAX_BLOCK) : block_reg;
        h_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;

        px            = 10'(chan_a) + 10'(chan_b) + 10'(chan_c);
        accept        = in_valid && (state_reg == ST_IDLE);
        last_col      = ({1'b0, col_reg} + WIDTH_W'(1)) == w_eff;
        last_row      = ({1'b0, row_reg} + (HEIGHT_W + 1)'(1)) == {1'b0, h_eff};
        seg_end       = last_col || (({1'b0, cit_reg} + BLOCK_W'(1)) >= b_eff);
        tile_last_row = last_row || (({1'b0, rit_reg} + BLOCK_W'(1)) >= b_eff);
        run_sum       = run_reg + SUM_W'(px);
        count_full    = ({1'b0, cit_reg} + BLOCK_W'(1)) * ({1'b0, rit_reg} + BLOCK_W'(1));

        mem_wdata = pend_acc_reg ? (mem_rdata + pend_sum_reg) : pend_sum_reg;
        mem_we    = (state_reg == ST_WB);
        div_start = (state_reg == ST_WB) && pend_out_reg;

        third_prod = div_quo[9:0] * 10'd683;
        avg        = third_prod[18:11];
        scaled     = (IDX_W + 8)'(avg) * (IDX_W + 8)'(GLYPH_COUNT);
        idx        = scaled[IDX_W+7:8];
        if (idx > IDX_W'(GLYPH_COUNT - 1))
        begin
            idx = IDX_W'(GLYPH_COUNT - 1);
        end
        if (invert_reg)
        begin
            idx = IDX_W'(GLYPH_COUNT - 1) - idx;
        end

        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        block_next     = block_reg;
        invert_next    = invert_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        rit_next       = rit_reg;
        cit_next       = cit_reg;
        tile_next      = tile_reg;
        run_next       = run_reg;
        pend_sum_next  = pend_sum_reg;
        pend_tile_next = pend_tile_reg;
        pend_acc_next  = pend_acc_reg;
        pend_out_next  = pend_out_reg;
        pend_last_next = pend_last_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        glyph_next     = glyph_reg;
        row_end_next   = row_end_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (seg_end)
                    begin
                        pend_sum_next  = run_sum;
                        pend_tile_next = tile_reg;
                        pend_acc_next  = (rit_reg != '0);
                        pend_out_next  = tile_last_row;
                        pend_last_next = last_col;
                        count_next     = count_full[COUNT_W-1:0];
                        run_next       = '0;
                        cit_next       = '0;
                        tile_next      = tile_reg + COL_W'(1);
                        state_next     = ST_WB;
                    end
                    else
                    begin
                        run_next = run_sum;
                        cit_next = cit_reg + TILE_W'(1);
                    end
                    if (last_col)
                    begin
                        col_next  = '0;
                        cit_next  = '0;
                        tile_next = '0;
                        if (last_row)
                        begin
                            row_next = '0;
                            rit_next = '0;
                        end
                        else
                        begin
                            row_next = row_reg + HEIGHT_W'(1);
                            rit_next = tile_last_row ? '0 : rit_reg + TILE_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
            end
            ST_WB:
            begin
                state_next = pend_out_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (!div_busy && (!out_valid_reg || !out_stall))
                begin
                    out_valid_next = 1'b1;
                    glyph_next     = glyph_lookup(idx);
                    row_end_next   = pend_last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_next  = cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_data[HEIGHT_W-1:0];
                REG_BLOCK_SIZE:   block_next  = cfg_data[BLOCK_W-1:0];
                REG_INVERT_MAP:   invert_next = cfg_data[0];
                default:          width_next  = width_reg;
            endcase
            col_next  = '0;
            row_next  = '0;
            rit_next  = '0;
            cit_next  = '0;
            tile_next = '0;
            run_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= WIDTH_W'(1);
            height_reg    <= HEIGHT_W'(1);
            block_reg     <= BLOCK_W'(1);
            invert_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            rit_reg       <= '0;
            cit_reg       <= '0;
            tile_reg      <= '0;
            run_reg       <= '0;
            pend_sum_reg  <= '0;
            pend_tile_reg <= '0;
            pend_acc_reg  <= 1'b0;
            pend_out_reg  <= 1'b0;
            pend_last_reg <= 1'b0;
            count_reg     <= COUNT_W'(1);
            out_valid_reg <= 1'b0;
            glyph_reg     <= '0;
            row_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            block_reg     <= block_next;
            invert_reg    <= invert_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            rit_reg       <= rit_next;
            cit_reg       <= cit_next;
            tile_reg      <= tile_next;
            run_reg       <= run_next;
            pend_sum_reg  <= pend_sum_next;
            pend_tile_reg <= pend_tile_next;
            pend_acc_reg  <= pend_acc_next;
            pend_out_reg  <= pend_out_next;
            pend_last_reg <= pend_last_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            glyph_reg     <= glyph_next;
            row_end_reg   <= row_end_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign glyph     = glyph_reg;
    assign row_end   = row_end_reg;

endmodule

>>> tb/sv/block_average_glyph_mapper_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the glyph words of the block average glyph mapper and compares them.
module block_average_glyph_mapper_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [7:0]                 chan_a,
    input  logic [7:0]                 chan_b,
    input  logic [7:0]                 chan_c,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [7:0]                 glyph,
    input  logic                       row_end,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [bagm_pkg::CFG_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         pending,
    output int                         glyphs_checked,
    output int                         pixels_taken
);
    import bagm_pkg::*;

    localparam int RAMP_LEN = 28;
    localparam logic [8*RAMP_LEN-1:0] GLYPH_RAMP = "N@#W$9876543210?!abc;:+=-,._";
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] code;
        logic       last_in_row;
    } tile_word_t;

    tile_word_t         expected_tiles[$];
    logic [WIDTH_W-1:0] width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [BLOCK_W-1:0] block_reg;
    logic               invert_reg;
    logic [SUM_W-1:0]   column_sums [MAX_WIDTH];
    logic [SUM_W-1:0]   segment_sum;
    int unsigned        pix_col;
    int unsigned        pix_row;
    int unsigned        tile_col;
    int unsigned        tile_row;
    int                 fail_total;
    int                 glyph_total;
    int                 pixel_total;
    tile_word_t         seen;
    tile_word_t         want;

    function automatic void restart_raster();
        pix_col = 0;
        pix_row = 0;
        tile_col = 0;
        tile_row = 0;
        segment_sum = '0;
    endfunction

    // Advances the raster position by one pixel and queues the glyph of a finished tile.
    function automatic void accumulate_pixel(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
        int unsigned      eff_w;
        int unsigned      eff_h;
        int unsigned      eff_b;
        int unsigned      level;
        int unsigned      column_tile;
        logic             last_col;
        logic             last_row;
        logic             seg_end;
        logic             tile_bottom;
        logic [SUM_W-1:0] tile_sum;
        tile_word_t       word;

        eff_w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        eff_h = (height_reg == 0) ? 1 : height_reg;
        eff_b = (block_reg == 0) ? 1 : (block_reg > MAX_BLOCK) ? MAX_BLOCK : block_reg;
        if (pix_col >= eff_w)
            pix_col = eff_w - 1;
        if (pix_row >= eff_h)
            pix_row = eff_h - 1;

        last_col = (pix_col + 1 == eff_w);
        last_row = (pix_row + 1 == eff_h);
        seg_end = last_col || (tile_col + 1 >= eff_b);
        tile_bottom = last_row || (tile_row + 1 >= eff_b);

        segment_sum = segment_sum + SUM_W'(a) + SUM_W'(b) + SUM_W'(c);

        if (seg_end)
        begin
            column_tile = pix_col / eff_b;
            tile_sum = segment_sum;
            if (tile_row != 0)
                tile_sum = column_sums[column_tile] + tile_sum;
            column_sums[column_tile] = tile_sum;
            if (tile_bottom)
            begin
                level = (tile_sum / ((tile_col + 1) * (tile_row + 1))) / 3;
                level = level * GLYPH_COUNT / 256;
                if (level > GLYPH_COUNT - 1)
                    level = GLYPH_COUNT - 1;
                if (invert_reg)
                    level = GLYPH_COUNT - 1 - level;
                word.code = (level < RAMP_LEN) ? GLYPH_RAMP[8*(RAMP_LEN-1-level) +: 8] : 8'h20;
                word.last_in_row = last_col;
                expected_tiles.push_back(word);
            end
            segment_sum = '0;
            tile_col = 0;
        end
        else
        begin
            tile_col++;
        end

        if (last_col)
        begin
            pix_col = 0;
            tile_col = 0;
            if (last_row)
            begin
                pix_row = 0;
                tile_row = 0;
            end
            else
            begin
                pix_row++;
                tile_row = tile_bottom ? 0 : tile_row + 1;
            end
        end
        else
        begin
            pix_col++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = WIDTH_W'(1);
            height_reg = HEIGHT_W'(1);
            block_reg = BLOCK_W'(1);
            invert_reg = 1'b0;
            restart_raster();
            expected_tiles.delete();
            fail_total = 0;
            glyph_total = 0;
            pixel_total = 0;
            mismatches <= 0;
            pending <= 0;
            glyphs_checked <= 0;
            pixels_taken <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen.code = glyph;
                seen.last_in_row = row_end;
                if (expected_tiles.size() == 0)
                begin
                    if (fail_total < MAX_REPORTS)
                        $display("%0t: unexpected glyph word %h ('%c') row_end %b",
                                 $realtime, seen.code, seen.code, seen.last_in_row);
                    fail_total++;
                end
                else
                begin
                    want = expected_tiles.pop_front();
                    if (seen !== want)
                    begin
                        if (fail_total < MAX_REPORTS)
                            $display({"%0t: glyph word %0d expected %h ('%c') row_end %b,",
                                      " got %h ('%c') row_end %b"},
                                     $realtime, glyph_total, want.code, want.code,
                                     want.last_in_row, seen.code, seen.code, seen.last_in_row);
                        fail_total++;
                    end
                end
                glyph_total++;
            end

            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_IMAGE_WIDTH:  width_reg = cfg_data[WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
                    REG_BLOCK_SIZE:   block_reg = cfg_data[BLOCK_W-1:0];
                    REG_INVERT_MAP:   invert_reg = cfg_data[0];
                    default:          ;
                endcase
                restart_raster();
            end

            if (in_valid && !in_stall)
            begin
                accumulate_pixel(chan_a, chan_b, chan_c);
                pixel_total++;
            end

            mismatches <= fail_total;
            pending <= expected_tiles.size();
            glyphs_checked <= glyph_total;
            pixels_taken <= pixel_total;
        end
    end

endmodule

>>> tb/sv/block_average_glyph_mapper_top_test.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the block average glyph mapper, with the checker beside the block.
module block_average_glyph_mapper_top_test;
    import bagm_pkg::*;

    localparam int RANDOM_PIXELS    = 1000;
    localparam int MIN_GLYPHS       = 48;
    localparam int SETTLE_CYCLES    = 40;
    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 4000;
    localparam int MAX_PHASE_PIXELS = 300;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [7:0]       chan_a = '0;
    logic [7:0]       chan_b = '0;
    logic [7:0]       chan_c = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       glyph;
    logic             row_end;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             hold_start = 1'b0;

    int mismatches;
    int pending;
    int glyphs_checked;
    int pixels_taken;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int settings_used = 0;
    int random_pixels = 0;
    int tone_mode = 0;
    int tone_base = 0;

    always #1 clk = ~clk;

    block_average_glyph_mapper_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .chan_a    (chan_a),
        .chan_b    (chan_b),
        .chan_c    (chan_c),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .glyph     (glyph),
        .row_end   (row_end),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    block_average_glyph_mapper_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .chan_a         (chan_a),
        .chan_b         (chan_b),
        .chan_c         (chan_c),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .glyph          (glyph),
        .row_end        (row_end),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .glyphs_checked (glyphs_checked),
        .pixels_taken   (pixels_taken)
    );

    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
        out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] channel_value();
        int v;
        case (tone_mode)
            0: v = $urandom_range(255);
            1:
            begin
                v = tone_base - 16;
                v += int'($urandom_range(32));
            end
            default: v = $urandom_range(1) ? 255 : 0;
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        chan_a <= a;
        chan_b <= b;
        chan_c <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // The pending count is a registered copy of the checker's queue size, so it lags the queue.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixels(input int count, input int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                settle();
            send_pixel(channel_value(), channel_value(), channel_value());
            random_pixels++;
        end
    endtask

    // Bits above each register's width carry junk, which the block must ignore.
    task automatic configure(input int w, input int h, input int b, input logic inv);
        logic [CFG_W-1:0] junk;
        settle();
        junk = CFG_W'($urandom);
        cfg_we <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= {junk[CFG_W-1:WIDTH_W], w[WIDTH_W-1:0]};
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= h[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= REG_BLOCK_SIZE;
        cfg_data <= {junk[CFG_W-1:BLOCK_W], b[BLOCK_W-1:0]};
        @(posedge clk);
        cfg_index <= REG_INVERT_MAP;
        cfg_data <= {junk[CFG_W-1:1], inv};
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int w;
        int h;
        int b;
        int n;
        int image_px;
        int pause_at;
        int saved_idle;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 29;
        recv_idle_pct <= 87;
        @(posedge clk);

        // After reset every pixel is a whole one-pixel image and a tile of its own.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd85, 8'd170, 8'd1);

        configure(1, 1, 1, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);

        // Zero width, height and block act as one.
        configure(0, 0, 0, 1'b0);
        send_pixel(8'd128, 8'd64, 8'd32);
        send_pixel(8'd200, 8'd100, 8'd50);

        // Clipped edge tiles, then wrap into the next image.
        configure(3, 3, 2, 1'b0);
        for (int i = 0; i < 11; i++)
            send_pixel(channel_value(), channel_value(), channel_value());

        // Oversized width and block are clamped; the next write restarts mid-image.
        configure(2047, 65535, 127, 1'b0);
        for (int i = 0; i < 3; i++)
            send_pixel(channel_value(), channel_value(), channel_value());

        // Receiver holds off while the sender keeps offering, so the block fills up.
        configure(6, 4, 1, 1'b0);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        saved_idle = send_idle_pct;
        send_idle_pct = 0;
        send_pixels(24, -1);
        send_idle_pct = saved_idle;

        while (random_pixels < RANDOM_PIXELS || glyphs_checked < MIN_GLYPHS)
        begin
            if (random_pixels < RANDOM_PIXELS / 3)
            begin
                send_idle_pct = 29;
                recv_idle_pct <= 87;
            end
            else if (random_pixels < 2 * RANDOM_PIXELS / 3)
            begin
                send_idle_pct = 87;
                recv_idle_pct <= 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end

            n = $urandom_range(99);
            h = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 8);
            if (n < 5)
                w = 0;
            else if (n < 10)
            begin
                w = $urandom_range(256, 1024);
                h = $urandom_range(1, 2);
            end
            else if (n < 20)
                w = $urandom_range(25, 64);
            else
                w = $urandom_range(1, 24);

            n = $urandom_range(99);
            if (n < 5)
                b = 0;
            else if (n < 8)
                b = MAX_BLOCK;
            else if (n < 10)
                b = $urandom_range(MAX_BLOCK + 1, 127);
            else if (n < 25)
                b = $urandom_range(7, 16);
            else
                b = $urandom_range(1, 6);

            configure(w, h, b, $urandom_range(1));
            tone_mode = $urandom_range(2);
            tone_base = $urandom_range(255);

            image_px = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            if ($urandom_range(99) < 15)
                n = $urandom_range(1, image_px);
            else
                n = image_px * $urandom_range(1, 2);
            if (n > MAX_PHASE_PIXELS)
                n = $urandom_range(64, MAX_PHASE_PIXELS);
            pause_at = ($urandom_range(99) < 10) ? $urandom_range(n - 1) : -1;
            send_pixels(n, pause_at);
        end

        settle();
        $display("Run covered %0d pixel words and %0d glyph words under %0d register settings,",
                 pixels_taken, glyphs_checked, settings_used);
        $display("with clipped tiles, image wrap, mid-image restarts, inversion and a long hold-off.");
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
